>>> src/rmds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmds_pkg
// Shared types and constants of the relocate move delta scan: command and
// result beat layouts, command kinds, register map and parameter defaults.
// ----------------------------------------------------------------------------
package rmds_pkg;

    localparam int KIND_W    = 2;
    localparam int NODE_W    = 8;
    localparam int DIST_IN_W = 16;
    localparam int ROUTE_W   = 4;
    localparam int POS_W     = 5;
    localparam int INS_W     = 6;
    localparam int LEN_W     = 6;
    localparam int BEST_W    = 19;
    localparam int SUM_W     = 48;
    localparam int COUNT_W   = 32;

    localparam int NODES_DEF         = 256;
    localparam int ROUTES_DEF        = 16;
    localparam int MAX_ROUTE_LEN_DEF = 32;
    localparam int DIST_BITS_DEF     = 16;

    localparam logic [KIND_W-1:0] KIND_DIST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LEN  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EVAL = 2'd3;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_DEPOT = 2'd0;

    // most negative delta kept for best tracking
    localparam logic signed [BEST_W-1:0] BEST_MIN = {1'b1, {(BEST_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [NODE_W-1:0]    from_node;
        logic [NODE_W-1:0]    to_node;
        logic [DIST_IN_W-1:0] distance;
        logic [ROUTE_W-1:0]   route_id;
        logic [POS_W-1:0]     position;
        logic [NODE_W-1:0]    node_value;
        logic [LEN_W-1:0]     route_length;
        logic [ROUTE_W-1:0]   dst_route;
        logic [INS_W-1:0]     insert_pos;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic signed [BEST_W-1:0] best_delta;
        logic                     improved;
        logic [ROUTE_W-1:0]       best_src_route;
        logic [POS_W-1:0]         best_src_pos;
        logic [ROUTE_W-1:0]       best_dst_route;
        logic [INS_W-1:0]         best_ins_pos;
        logic signed [SUM_W-1:0]  delta_sum;
        logic [COUNT_W-1:0]       check_count;
    } result_t;

endpackage
`default_nettype wire

>>> src/rmds_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmds_ram
// Generic single-port RAM: one address, write enable, registered read data.
// ----------------------------------------------------------------------------
module rmds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

>>> src/relocate_move_delta_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// relocate_move_delta_scan
// Relocate move evaluation for a vehicle routing local search: distance,
// route node and route length loading, delta scan with best move tracking.
// ----------------------------------------------------------------------------
// Usage
//   Command beats enter on item when start is high and busy is low. Load
//   beats (distance, route node, route length) write their RAM at the accept
//   edge and leave busy low, so they can arrive every cycle while idle.
//   An evaluate beat raises busy while a step sequencer reads both route
//   lengths and five route slots from the single-port length and node RAMs,
//   then six distances from the single-port distance RAM, one per cycle,
//   folding each into a shared add/subtract accumulator. The last step
//   updates the saturating sum, the check count and the best move; busy is
//   already low in that step, so the next evaluate beat can be accepted
//   while it completes.
//   An evaluate beat with last set produces one result beat on result, marked
//   by done for one cycle; done is registered from the final step, and the
//   scan state is cleared as done is set. The receiver cannot stall, results are never held.
//   Reset clears the depot register and the scan state; RAM contents are
//   undefined until written. The user writes depot_node over the APB port
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module relocate_move_delta_scan #(
    parameter int NODES         = rmds_pkg::NODES_DEF,
    parameter int ROUTES        = rmds_pkg::ROUTES_DEF,
    parameter int MAX_ROUTE_LEN = rmds_pkg::MAX_ROUTE_LEN_DEF,
    parameter int DIST_BITS     = rmds_pkg::DIST_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rmds_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [rmds_pkg::PDATA_W-1:0]   pwdata,
    output logic      [rmds_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    input  wire logic                           start,
    output logic                                busy,
    input  wire rmds_pkg::item_t                item,
    output logic                                done,
    output rmds_pkg::result_t                   result
);

    import rmds_pkg::*;

    localparam int DEPTH_D = NODES * NODES;
    localparam int DA_W    = $clog2(DEPTH_D);
    localparam int DEPTH_R = ROUTES * MAX_ROUTE_LEN;
    localparam int RA_W    = (DEPTH_R > 1) ? $clog2(DEPTH_R) : 1;
    localparam int LA_W    = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int DELTA_W = DIST_BITS + 3;
    localparam int WIDE_W  = ((DELTA_W > BEST_W) ? DELTA_W : BEST_W) + 1;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_C0  = 4'd0;
    localparam logic [STEP_W-1:0] ST_C1  = 4'd1;
    localparam logic [STEP_W-1:0] ST_C2  = 4'd2;
    localparam logic [STEP_W-1:0] ST_C3  = 4'd3;
    localparam logic [STEP_W-1:0] ST_C4  = 4'd4;
    localparam logic [STEP_W-1:0] ST_C5  = 4'd5;
    localparam logic [STEP_W-1:0] ST_C6  = 4'd6;
    localparam logic [STEP_W-1:0] ST_C7  = 4'd7;
    localparam logic [STEP_W-1:0] ST_C8  = 4'd8;
    localparam logic [STEP_W-1:0] ST_C9  = 4'd9;
    localparam logic [STEP_W-1:0] ST_C10 = 4'd10;

    function automatic logic [DA_W-1:0] dist_addr(input logic [NODE_W-1:0] a,
                                                  input logic [NODE_W-1:0] b);
        logic [31:0] ra;
        logic [31:0] rb;
        ra = 32'(a) % NODES;
        rb = 32'(b) % NODES;
        return DA_W'(ra * NODES + rb);
    endfunction

    function automatic logic [RA_W-1:0] route_addr(input logic [ROUTE_W-1:0] r,
                                                   input logic [6:0] idx);
        logic [31:0] rr;
        rr = 32'(r) % ROUTES;
        return RA_W'(rr * MAX_ROUTE_LEN + 32'(idx));
    endfunction

    function automatic logic [LA_W-1:0] len_addr(input logic [ROUTE_W-1:0] r);
        return LA_W'(32'(r) % ROUTES);
    endfunction

    // control
    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  done_reg, done_next;
    logic [NODE_W-1:0]     depot_reg;
    logic                  accept;
    logic                  final_step;

    // working item and gathered operands
    item_t                 item_reg;
    logic                  oob_reg;
    logic [LEN_W-1:0]      slen_reg, dlen_reg;
    logic [NODE_W-1:0]     node_reg, ps_reg, ns_reg, pt_reg, nt_reg;
    logic signed [DELTA_W-1:0] acc_reg, acc_next;

    // scan state
    logic signed [BEST_W-1:0] best_reg, best_next;
    logic                  found_reg, found_next;
    logic [ROUTE_W-1:0]    bsrc_reg, bsrc_next;
    logic [POS_W-1:0]      bpos_reg, bpos_next;
    logic [ROUTE_W-1:0]    bdst_reg, bdst_next;
    logic [INS_W-1:0]      bins_reg, bins_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    result_t               result_reg;

    // memory ports
    logic                  dist_we, node_we, len_we;
    logic [DA_W-1:0]       dist_addr_mux;
    logic [RA_W-1:0]       node_addr_mux;
    logic [LA_W-1:0]       len_addr_mux;
    logic [DIST_BITS-1:0]  dist_rdata;
    logic [NODE_W-1:0]     node_rdata;
    logic [LEN_W-1:0]      len_rdata;

    // sequencer read index
    logic signed [7:0]     pos_s, ins_s, ridx;
    logic [ROUTE_W-1:0]    rsel;
    logic                  oob;
    logic [NODE_W-1:0]     rnode;
    logic                  ns_end, nt_end;

    // final step arithmetic
    logic signed [DELTA_W-1:0] dval;
    logic                  sub;
    logic signed [DELTA_W-1:0] base;
    logic signed [WIDE_W-1:0]  wide_delta, held_w, best_min_w, best_w;
    logic                  take;
    logic signed [SUM_W:0] sum_w;
    logic signed [SUM_W-1:0] sum_sat;
    logic [COUNT_W-1:0]    count_inc;

    assign accept     = start && !busy;
    assign final_step = busy_reg && (step_reg == ST_C10);
    assign busy       = busy_reg && (step_reg != ST_C10);
    assign done       = done_reg;
    assign result     = result_reg;
    assign pready     = 1'b1;
    assign prdata     = (paddr == REG_DEPOT) ? PDATA_W'(depot_reg) : '0;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept && (item.kind == KIND_EVAL))
        begin
            busy_next = 1'b1;
            step_next = ST_C0;
        end
        else if (busy_reg)
        begin
            if (step_reg == ST_C10)
            begin
                busy_next = 1'b0;
                step_next = ST_C0;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // route slot reads
    // ------------------------------------------------------------------
    assign pos_s = $signed({3'b000, item_reg.position});
    assign ins_s = $signed({2'b00, item_reg.insert_pos});

    always_comb
    begin
        unique case (step_reg)
            ST_C0:   ridx = pos_s;
            ST_C1:   ridx = pos_s - 8'sd1;
            ST_C2:   ridx = pos_s + 8'sd1;
            ST_C3:   ridx = ins_s - 8'sd1;
            ST_C4:   ridx = ins_s;
            default: ridx = pos_s;
        endcase
    end

    assign rsel = (step_reg == ST_C3 || step_reg == ST_C4) ? item_reg.dst_route
                                                           : item_reg.route_id;
    assign oob  = (ridx < 8'sd0) || (int'(ridx) >= MAX_ROUTE_LEN);

    assign node_we = accept && (item.kind == KIND_NODE)
                     && (int'(item.position) < MAX_ROUTE_LEN);
    assign node_addr_mux = busy ? route_addr(rsel, ridx[6:0])
                                : route_addr(item.route_id, 7'(item.position));

    assign len_we = accept && (item.kind == KIND_LEN);
    assign len_addr_mux = !busy                ? len_addr(item.route_id)
                        : (step_reg == ST_C0) ? len_addr(item_reg.route_id)
                        :                       len_addr(item_reg.dst_route);

    // slot beyond the table or before the first position reads the depot
    assign rnode  = oob_reg ? depot_reg : node_rdata;
    assign ns_end = (6'(item_reg.position) + 6'd1) == slen_reg;
    assign nt_end = item_reg.insert_pos == dlen_reg;

    // ------------------------------------------------------------------
    // distance reads, one per step
    // ------------------------------------------------------------------
    assign dist_we = accept && (item.kind == KIND_DIST);

    always_comb
    begin
        if (!busy)
        begin
            dist_addr_mux = dist_addr(item.from_node, item.to_node);
        end
        else
        begin
            unique case (step_reg)
                ST_C3:   dist_addr_mux = dist_addr(ps_reg, node_reg);
                ST_C4:   dist_addr_mux = dist_addr(node_reg, ns_reg);
                ST_C5:   dist_addr_mux = dist_addr(pt_reg, node_reg);
                ST_C6:   dist_addr_mux = dist_addr(ps_reg, ns_reg);
                ST_C7:   dist_addr_mux = dist_addr(node_reg, nt_reg);
                ST_C8:   dist_addr_mux = dist_addr(pt_reg, nt_reg);
                default: dist_addr_mux = dist_addr(node_reg, node_reg);
            endcase
        end
    end

    // shared add/subtract: removal terms enter negative, insertion positive
    assign dval = $signed({3'b000, dist_rdata});
    assign sub  = (step_reg == ST_C4) || (step_reg == ST_C5) || (step_reg == ST_C9);
    assign base = (step_reg == ST_C4) ? '0 : acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (busy_reg && (step_reg >= ST_C4) && (step_reg <= ST_C9))
        begin
            acc_next = sub ? (base - dval) : (base + dval);
        end
    end

    // ------------------------------------------------------------------
    // final step: sum, count, best move
    // ------------------------------------------------------------------
    assign wide_delta = WIDE_W'(acc_reg);
    assign best_min_w = WIDE_W'(BEST_MIN);
    assign best_w     = WIDE_W'(best_reg);
    assign held_w     = (wide_delta < best_min_w) ? best_min_w : wide_delta;
    assign take       = held_w < best_w;

    assign sum_w   = $signed({sum_reg[SUM_W-1], sum_reg}) + (SUM_W+1)'(acc_reg);
    assign sum_sat = (sum_w[SUM_W] != sum_w[SUM_W-1])
                     ? (sum_w[SUM_W] ? SUM_MIN : SUM_MAX)
                     : sum_w[SUM_W-1:0];
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 32'd1;

    always_comb
    begin
        best_next  = best_reg;
        found_next = found_reg;
        bsrc_next  = bsrc_reg;
        bpos_next  = bpos_reg;
        bdst_next  = bdst_reg;
        bins_next  = bins_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        if (final_step)
        begin
            sum_next   = sum_sat;
            count_next = count_inc;
            if (take)
            begin
                best_next  = BEST_W'(held_w);
                found_next = 1'b1;
                bsrc_next  = item_reg.route_id;
                bpos_next  = item_reg.position;
                bdst_next  = item_reg.dst_route;
                bins_next  = item_reg.insert_pos;
            end
            done_next = item_reg.last;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= ST_C0;
            done_reg  <= 1'b0;
            depot_reg <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
            bsrc_reg  <= '0;
            bpos_reg  <= '0;
            bdst_reg  <= '0;
            bins_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
            if (psel && penable && pwrite && (paddr == REG_DEPOT))
            begin
                depot_reg <= pwdata[NODE_W-1:0];
            end
            if (done_next)
            begin
                // result beat leaves, scan starts over
                best_reg  <= '0;
                found_reg <= 1'b0;
                bsrc_reg  <= '0;
                bpos_reg  <= '0;
                bdst_reg  <= '0;
                bins_reg  <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                best_reg  <= best_next;
                found_reg <= found_next;
                bsrc_reg  <= bsrc_next;
                bpos_reg  <= bpos_next;
                bdst_reg  <= bdst_next;
                bins_reg  <= bins_next;
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        oob_reg <= oob;
        acc_reg <= acc_next;
        unique case (step_reg)
            ST_C1:
            begin
                slen_reg <= len_rdata;
                node_reg <= rnode;
            end
            ST_C2:
            begin
                dlen_reg <= len_rdata;
                ps_reg   <= rnode;
            end
            ST_C3:   ns_reg <= ns_end ? depot_reg : rnode;
            ST_C4:   pt_reg <= rnode;
            ST_C5:   nt_reg <= nt_end ? depot_reg : rnode;
            default: ;
        endcase
        if (done_next)
        begin
            result_reg.best_delta     <= best_next;
            result_reg.improved       <= found_next;
            result_reg.best_src_route <= bsrc_next;
            result_reg.best_src_pos   <= bpos_next;
            result_reg.best_dst_route <= bdst_next;
            result_reg.best_ins_pos   <= bins_next;
            result_reg.delta_sum      <= sum_next;
            result_reg.check_count    <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    rmds_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH_D),
        .AW    (DA_W)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .addr  (dist_addr_mux),
        .wdata (DIST_BITS'(item.distance)),
        .rdata (dist_rdata)
    );

    rmds_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH_R),
        .AW    (RA_W)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .addr  (node_addr_mux),
        .wdata (item.node_value),
        .rdata (node_rdata)
    );

    rmds_ram #(
        .WIDTH (LEN_W),
        .DEPTH (ROUTES),
        .AW    (LA_W)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .addr  (len_addr_mux),
        .wdata (item.route_length),
        .rdata (len_rdata)
    );

`ifndef SYNTHESIS
    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg && (step_reg == ST_C10)))
        else $error("result beat without a finished evaluation");

    a_eval_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.kind == KIND_EVAL)) |=> busy)
        else $error("evaluate beat did not start the sequencer");

    a_load_stays_free: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.kind != KIND_EVAL)) |=> !busy)
        else $error("load beat made the block busy");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_reg == ST_C0))
        else $error("step counter moved while idle");

    a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((count_reg == '0) && (sum_reg == '0) && !found_reg))
        else $error("scan state not cleared after result beat");

    a_improved_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.improved == (result.best_delta != '0)))
        else $error("improved flag disagrees with best delta");
`endif

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the relocate move delta scan. Fills the distance,
// route node and route length memories for a small pool of nodes, walks a
// directed table of commands, then random load and candidate traffic over
// several depot settings. Scan reports are checked against a behavioral copy.
// ----------------------------------------------------------------------------
module testbench;
    import rmds_pkg::*;

    localparam int      WATCHDOG_LIMIT = 1000;
    localparam int      DRAIN_CYCLES   = 16;
    localparam longint  SUM_HI         = longint'(SUM_MAX);
    localparam longint  SUM_LO         = longint'(SUM_MIN);
    localparam longint  HELD_LO        = longint'(BEST_MIN);

    typedef struct {
        item_t   cmd;
        bit      typed;
        result_t want;
    } step_row_t;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                start   = 1'b0;
    logic                busy;
    item_t               cmd_beat = '0;
    logic                done;
    result_t             result;

    // behavioral copy of the block state
    logic [15:0]         dist_mem [0:65535];
    logic [NODE_W-1:0]   route_mem [0:ROUTES_DEF-1][0:MAX_ROUTE_LEN_DEF-1];
    logic [LEN_W-1:0]    route_len [0:ROUTES_DEF-1];
    logic [NODE_W-1:0]   depot = '0;
    longint              best_val = 0;
    bit                  best_hit = 1'b0;
    int                  best_src_r = 0, best_src_p = 0, best_dst_r = 0, best_ins_p = 0;
    longint              run_sum = 0;
    logic [COUNT_W-1:0]  run_count = '0;

    result_t             scan_reports [$];
    logic [NODE_W-1:0]   pool [0:7];
    bit                  no_idle = 1'b0;
    int                  failures = 0;
    int                  cmds_sent = 0, evals_sent = 0, scans_sent = 0;
    int                  reports_seen = 0, depot_writes = 0, quiet_cycles = 0;

    relocate_move_delta_scan dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .item    (cmd_beat),
        .done    (done),
        .result  (result)
    );

    always #4 clk = ~clk;

    function automatic longint hop(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        return longint'(dist_mem[{a, b}]);
    endfunction

    // slots outside the table read as the depot
    function automatic logic [NODE_W-1:0] route_at(int r, int idx);
        if (idx < 0 || idx >= MAX_ROUTE_LEN_DEF)
            return depot;
        return route_mem[r][idx];
    endfunction

    task automatic step_scan(input item_t c, output bit emits, output result_t rpt);
        int                r, p, dr, ins, slen, dlen;
        logic [NODE_W-1:0] nd, ps, ns, pt, nt;
        longint            gain, cost, delta, held;
        emits = 1'b0;
        rpt   = '0;
        r     = c.route_id;
        p     = c.position;
        dr    = c.dst_route;
        ins   = c.insert_pos;
        case (c.kind)
            KIND_DIST: dist_mem[{c.from_node, c.to_node}] = c.distance;
            KIND_NODE: route_mem[r][p] = c.node_value;
            KIND_LEN:  route_len[r] = c.route_length;
            default:
            begin
                slen  = route_len[r];
                dlen  = route_len[dr];
                nd    = route_at(r, p);
                ps    = (p == 0) ? depot : route_at(r, p - 1);
                ns    = (p == slen - 1) ? depot : route_at(r, p + 1);
                pt    = (ins == 0) ? depot : route_at(dr, ins - 1);
                nt    = (ins == dlen) ? depot : route_at(dr, ins);
                gain  = hop(ps, nd) + hop(nd, ns) - hop(ps, ns);
                cost  = hop(pt, nd) + hop(nd, nt) - hop(pt, nt);
                delta = cost - gain;
                held  = (delta < HELD_LO) ? HELD_LO : delta;
                if (delta > 0 && run_sum > SUM_HI - delta)
                    run_sum = SUM_HI;
                else if (delta < 0 && run_sum < SUM_LO - delta)
                    run_sum = SUM_LO;
                else
                    run_sum += delta;
                if (run_count != '1)
                    run_count++;
                // strict compare keeps the first of equal deltas
                if (held < best_val)
                begin
                    best_val   = held;
                    best_hit   = 1'b1;
                    best_src_r = r;
                    best_src_p = p;
                    best_dst_r = dr;
                    best_ins_p = ins;
                end
                if (c.last)
                begin
                    emits              = 1'b1;
                    rpt.best_delta     = best_val[BEST_W-1:0];
                    rpt.improved       = best_hit;
                    rpt.best_src_route = best_src_r[ROUTE_W-1:0];
                    rpt.best_src_pos   = best_src_p[POS_W-1:0];
                    rpt.best_dst_route = best_dst_r[ROUTE_W-1:0];
                    rpt.best_ins_pos   = best_ins_p[INS_W-1:0];
                    rpt.delta_sum      = run_sum[SUM_W-1:0];
                    rpt.check_count    = run_count;
                    best_val   = 0;
                    best_hit   = 1'b0;
                    best_src_r = 0;
                    best_src_p = 0;
                    best_dst_r = 0;
                    best_ins_p = 0;
                    run_sum    = 0;
                    run_count  = '0;
                end
            end
        endcase
    endtask

    // unused fields carry random junk the block must ignore
    function automatic item_t junk_cmd();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t dist_cmd(logic [7:0] f, logic [7:0] t, logic [15:0] d);
        item_t c;
        c           = junk_cmd();
        c.kind      = KIND_DIST;
        c.from_node = f;
        c.to_node   = t;
        c.distance  = d;
        return c;
    endfunction

    function automatic item_t node_cmd(int r, int p, logic [7:0] n);
        item_t c;
        c            = junk_cmd();
        c.kind       = KIND_NODE;
        c.route_id   = r;
        c.position   = p;
        c.node_value = n;
        return c;
    endfunction

    function automatic item_t len_cmd(int r, int l);
        item_t c;
        c              = junk_cmd();
        c.kind         = KIND_LEN;
        c.route_id     = r;
        c.route_length = l;
        return c;
    endfunction

    function automatic item_t eval_cmd(int r, int p, int dr, int ins, bit lst);
        item_t c;
        c            = junk_cmd();
        c.kind       = KIND_EVAL;
        c.route_id   = r;
        c.position   = p;
        c.dst_route  = dr;
        c.insert_pos = ins;
        c.last       = lst;
        return c;
    endfunction

    function automatic logic [15:0] rand_dist();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, 15);
            1:       return $urandom_range(0, 65535);
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    function automatic int pick_gap();
        int sel;
        if (no_idle)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic item_t rand_cmd();
        item_t c;
        int    sel, slen, dlen;
        c   = junk_cmd();
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            c.kind = KIND_EVAL;
            c.last = ($urandom_range(0, 7) == 0);
            slen   = route_len[c.route_id];
            dlen   = route_len[c.dst_route];
            if ($urandom_range(0, 99) < 85)
            begin
                c.position   = (slen == 0) ? 0 :
                               $urandom_range(0, ((slen > 32) ? 32 : slen) - 1);
                c.insert_pos = $urandom_range(0, (dlen > 32) ? 32 : dlen);
            end
            else
                c.insert_pos = $urandom_range(0, 63);
        end
        else if (sel < 82)
        begin
            c.kind = KIND_DIST;
            if ($urandom_range(0, 99) < 60)
            begin
                c.from_node = pool[$urandom_range(0, 7)];
                c.to_node   = pool[$urandom_range(0, 7)];
            end
            c.distance = rand_dist();
        end
        else if (sel < 92)
        begin
            c.kind       = KIND_NODE;
            c.node_value = pool[$urandom_range(0, 7)];
        end
        else
        begin
            c.kind         = KIND_LEN;
            c.route_length = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 32) :
                                                             $urandom_range(33, 63);
        end
        return c;
    endfunction

    // start stays high across back-to-back beats
    task automatic send_cmd(input item_t c, input bit typed, input result_t want);
        int      gap;
        bit      emits;
        result_t rpt;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_beat <= c;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        step_scan(c, emits, rpt);
        cmds_sent++;
        if (c.kind == KIND_EVAL)
            evals_sent++;
        if (emits)
        begin
            scans_sent++;
            scan_reports.push_back(typed ? want : rpt);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (scan_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_DEPOT;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_depot(input logic [NODE_W-1:0] v);
        logic [PDATA_W-1:0] got;
        apb_access(1'b1, {{(PDATA_W-NODE_W){1'b0}}, v}, got);
        depot = v;
        depot_writes++;
        @(posedge clk);
        apb_access(1'b0, '0, got);
        if (got !== {{(PDATA_W-NODE_W){1'b0}}, v})
        begin
            failures++;
            $display("%0t: depot readback expected %0d got %0d", $time, v, got);
        end
    endtask

    task automatic report_field(input string nm, input logic signed [63:0] w,
                                input logic signed [63:0] g);
        if (g !== w)
        begin
            failures++;
            $display("%0t: %s expected %0d got %0d", $time, nm, w, g);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            reports_seen++;
            if (scan_reports.size() == 0)
            begin
                failures++;
                $display("%0t: scan report with none pending, got %p", $time, result);
            end
            else
            begin
                report_field("best_delta", scan_reports[0].best_delta, result.best_delta);
                report_field("improved", scan_reports[0].improved, result.improved);
                report_field("best_src_route", scan_reports[0].best_src_route,
                             result.best_src_route);
                report_field("best_src_pos", scan_reports[0].best_src_pos,
                             result.best_src_pos);
                report_field("best_dst_route", scan_reports[0].best_dst_route,
                             result.best_dst_route);
                report_field("best_ins_pos", scan_reports[0].best_ins_pos,
                             result.best_ins_pos);
                report_field("delta_sum", scan_reports[0].delta_sum, result.delta_sum);
                report_field("check_count", scan_reports[0].check_count, result.check_count);
                void'(scan_reports.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        step_row_t rows [$];
        result_t   flat;
        result_t   gained;
        int        ph, n, i, j, k;
        bit        fresh;

        pool[0] = 8'h00;
        pool[1] = 8'hFF;
        pool[2] = 8'h55;
        pool[3] = 8'hAA;
        for (i = 4; i < 8; i++)
        begin
            do
            begin
                pool[i] = $urandom_range(1, 254);
                fresh   = 1'b1;
                for (j = 0; j < i; j++)
                    if (pool[j] == pool[i])
                        fresh = 1'b0;
            end
            while (!fresh);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_depot(8'h00);

        // fill every entry a candidate can reach before any evaluation
        for (i = 0; i < 8; i++)
            for (j = 0; j < 8; j++)
                send_cmd(dist_cmd(pool[i], pool[j], rand_dist()), 1'b0, '0);
        for (i = 0; i < ROUTES_DEF; i++)
            for (j = 0; j < MAX_ROUTE_LEN_DEF; j++)
                send_cmd(node_cmd(i, j, pool[$urandom_range(0, 7)]), 1'b0, '0);
        for (i = 0; i < ROUTES_DEF; i++)
            send_cmd(len_cmd(i, $urandom_range(0, 32)), 1'b0, '0);

        settle();
        set_depot(8'hFF);

        flat   = '{best_delta: '0, improved: 1'b0, best_src_route: '0, best_src_pos: '0,
                   best_dst_route: '0, best_ins_pos: '0, delta_sum: '0, check_count: 32'd1};
        gained = '{best_delta: -19'sd131070, improved: 1'b1, best_src_route: 4'd0,
                   best_src_pos: 5'd0, best_dst_route: 4'd1, best_ins_pos: 6'd0,
                   delta_sum: -48'sd131070, check_count: 32'd1};

        rows.push_back('{dist_cmd(8'hFF, 8'h00, 16'hFFFF), 1'b0, '0});
        rows[0].cmd.last = 1'b1;
        rows.push_back('{dist_cmd(8'h00, 8'hFF, 16'hFFFF), 1'b0, '0});
        rows.push_back('{dist_cmd(8'hFF, 8'hFF, 16'h0000), 1'b0, '0});
        rows.push_back('{dist_cmd(8'h00, 8'hAA, 16'h0000), 1'b0, '0});
        rows.push_back('{dist_cmd(8'hFF, 8'hAA, 16'hFFFF), 1'b0, '0});
        rows.push_back('{len_cmd(0, 1), 1'b0, '0});
        rows.push_back('{node_cmd(0, 0, 8'h00), 1'b0, '0});
        rows.push_back('{len_cmd(1, 0), 1'b0, '0});
        // moving a lone customer into an empty route is neutral
        rows.push_back('{eval_cmd(0, 0, 1, 0, 1'b1), 1'b1, flat});
        rows.push_back('{len_cmd(1, 1), 1'b0, '0});
        rows.push_back('{node_cmd(1, 0, 8'hAA), 1'b0, '0});
        rows.push_back('{eval_cmd(0, 0, 1, 0, 1'b1), 1'b1, gained});
        rows.push_back('{eval_cmd(1, 0, 0, 1, 1'b0), 1'b0, '0});
        rows.push_back('{len_cmd(2, 32), 1'b0, '0});
        rows.push_back('{eval_cmd(2, 31, 2, 32, 1'b0), 1'b0, '0});
        rows.push_back('{len_cmd(3, 63), 1'b0, '0});
        rows.push_back('{eval_cmd(3, 5, 3, 40, 1'b0), 1'b0, '0});
        rows.push_back('{len_cmd(4, 0), 1'b0, '0});
        rows.push_back('{eval_cmd(4, 0, 4, 0, 1'b0), 1'b0, '0});
        rows.push_back('{dist_cmd(8'h00, 8'h00, 16'hFFFF), 1'b0, '0});
        rows.push_back('{eval_cmd(15, 31, 14, 63, 1'b0), 1'b0, '0});
        rows.push_back('{eval_cmd(0, 0, 1, 1, 1'b1), 1'b0, '0});
        rows.push_back('{node_cmd(1, 31, 8'hFF), 1'b0, '0});
        rows[rows.size()-1].cmd.last = 1'b1;

        foreach (rows[k])
            send_cmd(rows[k].cmd, rows[k].typed, rows[k].want);

        for (ph = 0; ph < 5; ph++)
        begin
            settle();
            set_depot((ph == 4) ? 8'h00 : pool[$urandom_range(0, 7)]);
            no_idle = (ph == 2);
            for (n = 0; n < 160; n++)
                send_cmd(rand_cmd(), 1'b0, '0);
        end
        no_idle = 1'b0;
        while (scans_sent < 48)
            send_cmd(rand_cmd(), 1'b0, '0);

        settle();
        $display("covered %0d commands, %0d candidate checks, %0d scan reports",
                 cmds_sent, evals_sent, reports_seen);
        $display("across %0d depot settings with %0d mismatches", depot_writes, failures);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
src/rmds_pkg.sv
src/rmds_ram.sv
src/relocate_move_delta_scan.sv
tb/sv/testbench.sv
